>>> hdl/erx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erx_pkg
// Shared types, constants and the CRC-32 byte step for the receive checker.
// ----------------------------------------------------------------------------
package erx_pkg;

  // frame byte counter width, saturates at all ones
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // config register widths and indexes
  localparam int MAC_W     = 48;
  localparam int LEN_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_STATION_MAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME   = 2'd2;

  localparam logic [MAC_W-1:0] STATION_MAC_RST = 48'h0AFF_FEFD_FCFB;
  localparam logic [LEN_W-1:0] MIN_FRAME_RST   = 11'd64;
  localparam logic [LEN_W-1:0] MAX_FRAME_RST   = 11'd1530;

  // frame layout and protocol constants
  localparam logic [7:0]  BCAST_BYTE  = 8'hff;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_ARP   = 16'h0806;
  localparam logic [CNT_W-1:0] ADDR_BYTES   = CNT_W'(6);
  localparam logic [CNT_W-1:0] TYPE_HI_POS  = CNT_W'(12);
  localparam logic [CNT_W-1:0] TYPE_LO_POS  = CNT_W'(13);
  localparam logic [CNT_W-1:0] MIN_HDR_LEN  = CNT_W'(14);
  localparam logic [CNT_W-1:0] FCS_BYTES    = CNT_W'(4);

  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;
  localparam logic [31:0] CRC_RESIDUE   = 32'hDEBB_20E3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ADDR_ERR = 3'd1;
  localparam logic [2:0] ST_TYPE_ERR = 3'd2;
  localparam logic [2:0] ST_LEN_ERR  = 3'd3;
  localparam logic [2:0] ST_FCS_ERR  = 3'd4;

  // short queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [LEN_W-1:0] payload_bytes;
    logic [31:0]      good_frames;
    logic [31:0]      bad_frames;
  } out_item_t;

  // one classified byte handed from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [CNT_W-1:0] count;
    logic             addr_ok;
    logic             type_ok;
  } q_entry_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/erx_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erx_front
// Accepts frame bytes, tracks position, address match and ethertype.
// ----------------------------------------------------------------------------
module erx_front import erx_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  input  wire logic [MAC_W-1:0] station_mac,
  input  wire logic             q_full,
  output logic                  q_push,
  output q_entry_t              q_wentry
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [1:0]       flags_r, flags_nxt, flags_upd;
  logic [7:0]       type_hi_r, type_hi_nxt, type_hi_upd;
  logic             type_ok_r, type_ok_nxt, type_ok_upd;
  logic [7:0]       own_byte;
  logic [15:0]      etype;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  // station address byte for the current position
  always_comb begin
    unique case (cnt_r[2:0])
      3'd0:    own_byte = station_mac[47:40];
      3'd1:    own_byte = station_mac[39:32];
      3'd2:    own_byte = station_mac[31:24];
      3'd3:    own_byte = station_mac[23:16];
      3'd4:    own_byte = station_mac[15:8];
      default: own_byte = station_mac[7:0];
    endcase
  end

  assign etype = {type_hi_r, in_item.frame_byte};

  // per-byte header classification
  always_comb begin
    flags_upd   = flags_r;
    type_hi_upd = type_hi_r;
    type_ok_upd = type_ok_r;
    if (cnt_r < ADDR_BYTES) begin
      if (in_item.frame_byte != own_byte) begin
        flags_upd[0] = 1'b0;
      end
      if (in_item.frame_byte != BCAST_BYTE) begin
        flags_upd[1] = 1'b0;
      end
    end else if (cnt_r == TYPE_HI_POS) begin
      type_hi_upd = in_item.frame_byte;
    end else if (cnt_r == TYPE_LO_POS) begin
      type_ok_upd = (etype == ETYPE_IPV4) || (etype == ETYPE_ARP);
    end
    cnt_inc = (cnt_r < CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
  end

  // entry pushed into the queue
  always_comb begin
    q_wentry.data    = in_item.frame_byte;
    q_wentry.last    = in_item.frame_last;
    q_wentry.count   = cnt_inc;
    q_wentry.addr_ok = |flags_upd;
    q_wentry.type_ok = type_ok_upd;
  end

  // frame state, cleared after the final byte
  always_comb begin
    cnt_nxt     = cnt_r;
    flags_nxt   = flags_r;
    type_hi_nxt = type_hi_r;
    type_ok_nxt = type_ok_r;
    if (q_push) begin
      if (in_item.frame_last) begin
        cnt_nxt     = '0;
        flags_nxt   = 2'b11;
        type_hi_nxt = '0;
        type_ok_nxt = 1'b0;
      end else begin
        cnt_nxt     = cnt_inc;
        flags_nxt   = flags_upd;
        type_hi_nxt = type_hi_upd;
        type_ok_nxt = type_ok_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      flags_r   <= 2'b11;
      type_hi_r <= '0;
      type_ok_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      flags_r   <= flags_nxt;
      type_hi_r <= type_hi_nxt;
      type_ok_r <= type_ok_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/erx_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erx_queue
// Short fifo of classified bytes between front and back.
// ----------------------------------------------------------------------------
module erx_queue import erx_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t wentry,
  output logic          full,
  output logic          rd_valid,
  output q_entry_t      rentry,
  input  wire logic     pop
);

  q_entry_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rentry   = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wentry;
    end
  end

endmodule
`default_nettype wire

>>> hdl/erx_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erx_back
// Runs the frame crc, judges each frame and holds the result register.
// ----------------------------------------------------------------------------
module erx_back import erx_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire q_entry_t         q_entry,
  output logic                  q_pop,
  input  wire logic [LEN_W-1:0] min_frame_bytes,
  input  wire logic [LEN_W-1:0] max_frame_bytes,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item
);

  logic [31:0]      crc_r, crc_nxt, crc_step;
  logic [31:0]      good_r, good_nxt, bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic [2:0]       status;
  logic [CNT_W-1:0] n;
  logic             len_bad;
  logic             finish;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // take a byte unless it ends a frame and the result slot is still held
  assign q_pop  = q_valid & (~q_entry.last | ~out_valid_r | ~out_stall);
  assign finish = q_pop & q_entry.last;

  assign crc_step = crc32_byte(crc_r, q_entry.data);
  assign n        = q_entry.count;
  assign len_bad  = (n < CNT_W'(min_frame_bytes)) || (n > CNT_W'(max_frame_bytes));

  // frame verdict, first failing check wins
  always_comb begin
    if (n < MIN_HDR_LEN) begin
      status = ST_LEN_ERR;
    end else if (!q_entry.addr_ok) begin
      status = ST_ADDR_ERR;
    end else if (!q_entry.type_ok) begin
      status = ST_TYPE_ERR;
    end else if (len_bad) begin
      status = ST_LEN_ERR;
    end else if (crc_step != CRC_RESIDUE) begin
      status = ST_FCS_ERR;
    end else begin
      status = ST_OK;
    end
  end

  // crc, counters and result register
  always_comb begin
    crc_nxt       = crc_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_item_nxt  = out_item_r;
    if (q_pop) begin
      crc_nxt = q_entry.last ? CRC_INIT : crc_step;
    end
    if (finish) begin
      if (status == ST_OK) begin
        good_nxt = good_r + 32'd1;
      end else begin
        bad_nxt = bad_r + 32'd1;
      end
      out_valid_nxt              = 1'b1;
      out_item_nxt.status        = status;
      out_item_nxt.payload_bytes = (status == ST_OK) ? LEN_W'(n - FCS_BYTES) : '0;
      out_item_nxt.good_frames   = good_nxt;
      out_item_nxt.bad_frames    = bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/ethernet_rx_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: a final byte is written into the queue, then popped and judged into the
//   registered result; it waits behind any earlier bytes still in the queue.
// Throughput: one byte per clock while nothing stalls, set by the combinational crc byte step.
// Reset (rst_n low, synchronous): config registers to their defaults, frame
//   state, counters and the four-entry queue cleared; no clearing pass.
// ----------------------------------------------------------------------------
// ethernet_rx_frame_checker
// Byte-wide ethernet receive check: address filter, ethertype, length, fcs.
// ----------------------------------------------------------------------------
module ethernet_rx_frame_checker import erx_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic [MAC_W-1:0] station_mac_r;
  logic [LEN_W-1:0] min_frame_r, max_frame_r;
  logic             q_full, q_push, q_valid, q_pop;
  q_entry_t         q_wentry, q_rentry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_mac_r <= STATION_MAC_RST;
      min_frame_r   <= MIN_FRAME_RST;
      max_frame_r   <= MAX_FRAME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STATION_MAC: station_mac_r <= cfg_wdata[MAC_W-1:0];
        REG_MIN_FRAME:   min_frame_r   <= cfg_wdata[LEN_W-1:0];
        REG_MAX_FRAME:   max_frame_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  erx_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .station_mac (station_mac_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wentry    (q_wentry)
  );

  erx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wentry   (q_wentry),
    .full     (q_full),
    .rd_valid (q_valid),
    .rentry   (q_rentry),
    .pop      (q_pop)
  );

  erx_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_rentry),
    .q_pop           (q_pop),
    .min_frame_bytes (min_frame_r),
    .max_frame_bytes (max_frame_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item)
  );

  // a finished frame always lands in the result register
  a_finish_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_rentry.last |=> out_valid)
    else $error("frame end popped without a result");

  // accepted frames carry at least ten payload bytes
  a_ok_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_OK |-> out_item.payload_bytes >= LEN_W'(10))
    else $error("accepted frame with short payload");

  // rejected frames report no payload
  a_bad_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.payload_bytes == '0)
    else $error("rejected frame with payload");

  // a byte never enters the queue while it is full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("queue overflow");

endmodule
`default_nettype wire
